@@ rtl/core/bsrbv_pkg.sv @@
// Package for the bounded stack with remove by value.
// Holds status and command codes and the result record type.
// No dependencies.
`default_nettype none

package bsrbv_pkg;

    // Widths fixed by the item fields
    localparam int WORD_W  = 32;
    localparam int DEPTH_W = 4;

    // Command codes
    localparam logic CMD_PUSH   = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // One finished result
    typedef struct packed {
        logic [1:0]                status;
        logic [DEPTH_W-1:0]        depth_after;
        logic signed [WORD_W-1:0]  top_value;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/core/bsrbv_ram.sv @@
// Entry storage for the stack: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bsrbv_ram #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = 32
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bsrbv_seq.sv @@
// Sequencer for the stack: decodes one command, scans entries with a single
// comparator, moves entries down one a cycle and reads back the new top.
// Depends on bsrbv_pkg and bsrbv_ram.
`default_nettype none

module bsrbv_seq #(
    parameter int STACK_DEPTH = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            command,
    input  wire logic signed [bsrbv_pkg::WORD_W-1:0] value,
    output logic                                 res_valid,
    input  wire logic                            res_take,
    output bsrbv_pkg::res_t                      res
);

    import bsrbv_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int IX_W   = CNT_W + 1;

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_TOPRD  = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [ADDR_W-1:0]        idx_reg,   idx_next;
    logic                     cmd_reg,   cmd_next;
    logic [WORD_W-1:0]        word_reg,  word_next;
    logic [1:0]               stat_reg,  stat_next;

    // Memory port signals
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [WORD_W-1:0]        wr_data;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic [WORD_W-1:0]        rd_data;

    // Index arithmetic and the shared compare
    logic [CNT_W-1:0]         cnt_m1;
    logic [IX_W-1:0]          count_ext;
    logic [IX_W-1:0]          idx_p1_ext;
    logic [IX_W-1:0]          idx_p2_ext;
    logic                     hit;
    logic                     full;

    assign cnt_m1     = count_reg - CNT_W'(1);
    assign count_ext  = IX_W'(count_reg);
    assign idx_p1_ext = IX_W'(idx_reg) + IX_W'(1);
    assign idx_p2_ext = IX_W'(idx_reg) + IX_W'(2);
    assign hit        = (rd_data == word_reg);
    assign full       = (count_reg == CNT_W'(STACK_DEPTH));

    bsrbv_ram #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (WORD_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Next-state and datapath control
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        cmd_next   = cmd_reg;
        word_next  = word_reg;
        stat_next  = stat_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = rd_data;
        rd_en      = 1'b0;
        rd_addr    = idx_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next   = command;
                    word_next  = value;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (cmd_reg == CMD_PUSH)
                begin
                    if (full)
                    begin
                        stat_next = ST_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = ADDR_W'(count_reg);
                        wr_data    = word_reg;
                        count_next = count_reg + CNT_W'(1);
                        stat_next  = ST_DONE;
                    end
                    state_next = S_TOPRD;
                end
                else if (count_reg == '0)
                begin
                    stat_next  = ST_EMPTY;
                    state_next = S_TOPRD;
                end
                else
                begin
                    // start the search at the top entry
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(cnt_m1);
                    idx_next   = ADDR_W'(cnt_m1);
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // rd_data holds the entry at idx_reg
                if (hit)
                begin
                    if (idx_p1_ext < count_ext)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = ADDR_W'(idx_p1_ext);
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        count_next = cnt_m1;
                        stat_next  = ST_DONE;
                        state_next = S_TOPRD;
                    end
                end
                else if (idx_reg == '0)
                begin
                    stat_next  = ST_NOT_FOUND;
                    state_next = S_TOPRD;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg - ADDR_W'(1);
                    idx_next = idx_reg - ADDR_W'(1);
                end
            end

            S_SHIFT:
            begin
                // rd_data holds the entry above idx_reg; move it down
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = rd_data;
                idx_next = ADDR_W'(idx_p1_ext);
                if (idx_p2_ext < count_ext)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ADDR_W'(idx_p2_ext);
                end
                else
                begin
                    count_next = cnt_m1;
                    stat_next  = ST_DONE;
                    state_next = S_TOPRD;
                end
            end

            S_TOPRD:
            begin
                if (count_reg != '0)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ADDR_W'(cnt_m1);
                end
                state_next = S_FIN;
            end

            S_FIN:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result record
    always_comb
    begin
        res.status      = stat_reg;
        res.depth_after = DEPTH_W'(count_reg);
        res.top_value   = (count_reg == '0) ? '0 : rd_data;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        cmd_reg  <= cmd_next;
        word_reg <= word_next;
        stat_reg <= stat_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/bounded_stack_remove_by_value.sv @@
// Bounded LIFO stack of signed 32-bit words with push and remove by value.
// A push passes from acceptance through the decide, top-read and finish states
// back to idle; a remove on a non-empty stack also compares entries top down,
// up to the match or the bottom, and then moves each entry above the match down
// one slot. One comparator and one read port of the entry memory set this pace:
// every entry examined or moved costs one memory read. A result waits in the
// output register without holding up the next item, which is taken once the
// sequencer is back in idle. After reset the stack is empty; no clearing pass.
// Depends on bsrbv_pkg and bsrbv_seq.
`default_nettype none

module bounded_stack_remove_by_value #(
    parameter int STACK_DEPTH = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                command,
    input  wire logic signed [bsrbv_pkg::WORD_W-1:0] value,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [1:0]                               status,
    output logic [bsrbv_pkg::DEPTH_W-1:0]            depth_after,
    output logic signed [bsrbv_pkg::WORD_W-1:0]      top_value
);

    import bsrbv_pkg::*;

    logic   res_valid;
    logic   res_take;
    res_t   res;
    logic   out_valid_reg, out_valid_next;
    res_t   out_res_reg;

    bsrbv_seq #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .value     (value),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    // Output register takes a result when empty or being drained
    assign res_take = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_res_reg.status;
    assign depth_after = out_res_reg.depth_after;
    assign top_value   = out_res_reg.top_value;

endmodule

`default_nettype wire
